// File: rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, register indexes and types for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  // default fixed point and sample widths
  localparam int FRACTION_BITS = 16;
  localparam int SAMPLE_BITS   = 8;

  // fixed field and state widths
  localparam int REG_BITS       = 24;
  localparam int EST_BITS       = 24;
  localparam int COV_BITS       = 26;
  localparam int GAIN_BITS      = 17;
  localparam int CFG_INDEX_BITS = 2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_ESTIMATE  = 2'd2;

  // register reset values
  localparam logic [REG_BITS-1:0] PROCESS_NOISE_RESET     = 24'd6554;
  localparam logic [REG_BITS-1:0] MEASUREMENT_NOISE_RESET = 24'd327680;
  localparam logic [REG_BITS-1:0] INITIAL_ESTIMATE_RESET  = 24'd0;

  // largest estimate
  localparam logic [EST_BITS-1:0] EST_MAX = '1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/core/skf_ifs.sv
// ----------------------------------------------------------------------------
// skf_ifs
// Valid/ready channels of the scalar Kalman filter: samples, results, config.
// ----------------------------------------------------------------------------

// sample channel
interface skf_sample_if #(
  parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// result channel
interface skf_result_if;
  logic                             valid;
  logic                             ready;
  logic [skf_pkg::EST_BITS-1:0]     filtered_value;
  logic [skf_pkg::GAIN_BITS-1:0]    gain;

  modport source (output valid, output filtered_value, output gain, input ready);
  modport sink   (input valid, input filtered_value, input gain, output ready);
endinterface

// configuration write channel
interface skf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [skf_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [skf_pkg::REG_BITS-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/skf_divider.sv
// ----------------------------------------------------------------------------
// skf_divider
// Restoring serial divider for the gain: (num << FRACTION_BITS) / den,
// one quotient bit per cycle; done is raised together with the final quotient
// bit.
// ----------------------------------------------------------------------------
module skf_divider #(
  parameter int FRACTION_BITS = skf_pkg::FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [skf_pkg::COV_BITS-1:0]  num,
  input  logic [skf_pkg::COV_BITS:0]    den,
  output logic [FRACTION_BITS:0]        quot,
  output skf_pkg::div_status_t          stat
);

  localparam int QW   = FRACTION_BITS + 1;
  localparam int CB   = skf_pkg::COV_BITS;
  localparam int CNTW = $clog2(QW + 1);

  logic [CB:0]      rem;
  logic [CB:0]      dvs;
  logic             nbit;
  logic [CNTW-1:0]  cnt;
  logic             done;
  logic [CB+1:0]    trial;
  logic             fits;

  // shift in the next dividend bit and compare
  assign trial = {rem, nbit};
  assign fits  = trial >= {1'b0, dvs};

  assign stat.busy = cnt != '0;
  assign stat.done = done;

  // quotient bit iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      rem  <= {2'b00, num[CB-1:1]};
      nbit <= num[0];
      dvs  <= den;
      quot <= '0;
      cnt  <= CNTW'(QW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      // remainder stays below the divisor, so the low bits carry the difference
      if (fits) begin
        rem <= trial[CB:0] - dvs;
      end else begin
        rem <= trial[CB:0];
      end
      quot <= {quot[QW-2:0], fits};
      nbit <= 1'b0;
      cnt  <= cnt - 1'b1;
      done <= cnt == CNTW'(1);
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// File: rtl/core/skf_mult.sv
// ----------------------------------------------------------------------------
// skf_mult
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module skf_mult #(
  parameter int A_BITS = skf_pkg::FRACTION_BITS + 1,
  parameter int B_BITS = skf_pkg::COV_BITS
) (
  input  logic                      clk,
  input  logic [A_BITS-1:0]         a,
  input  logic [B_BITS-1:0]         b,
  output logic [A_BITS+B_BITS-1:0]  prod
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= (A_BITS + B_BITS)'(a) * (A_BITS + B_BITS)'(b);
  end

endmodule

// File: rtl/core/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter on integer sensor samples, fixed point.
// ----------------------------------------------------------------------------
// Each accepted sample steps through S_START, S_DIV, S_MUL_LO, S_MUL_HI,
// S_MUL_COV and S_UPDATE; S_DIV waits for the divider and S_UPDATE waits
// until the output register is free. The gain division runs one quotient bit
// per cycle in a serial divider, and one shared multiplier then forms the
// estimate correction in two halves and the covariance update. The block takes
// no sample while an update is in progress, but takes the next one while its
// result still waits in the output register. Any write to a known register
// reloads the estimate from initial_estimate and sets the covariance to 1.0;
// writes belong to idle periods only.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int FRACTION_BITS = skf_pkg::FRACTION_BITS,
  parameter int SAMPLE_BITS   = skf_pkg::SAMPLE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  skf_sample_if.sink    samples,
  skf_result_if.source  results,
  skf_cfg_if.sink       cfg
);

  localparam int CB  = skf_pkg::COV_BITS;
  localparam int EB  = skf_pkg::EST_BITS;
  localparam int KW  = FRACTION_BITS + 1;
  localparam int DW  = SAMPLE_BITS + FRACTION_BITS;
  localparam int XW  = (DW > EB) ? DW : EB;
  localparam int DPW = 2 * CB;
  localparam int PW  = KW + CB;
  localparam int AW  = KW + DPW;
  localparam int CRW = AW - FRACTION_BITS;

  localparam logic [KW-1:0] ONE_K   = KW'(1) << FRACTION_BITS;
  localparam logic [CB-1:0] COV_ONE = CB'(1) << FRACTION_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_COV,
    S_UPDATE
  } state_t;

  state_t state;

  // configuration and filter state
  logic [skf_pkg::REG_BITS-1:0] q_noise;
  logic [skf_pkg::REG_BITS-1:0] r_noise;
  logic [skf_pkg::REG_BITS-1:0] init_est;
  logic [EB-1:0]                estimate;
  logic [CB-1:0]                cov;

  // per-sample working registers
  logic [XW-1:0]  z;
  logic [CB-1:0]  p;
  logic           den_zero;
  logic           up;
  logic [XW-1:0]  diff;
  logic [KW-1:0]  k;
  logic [AW-1:0]  acc;

  // output register
  logic                          out_valid;
  logic [EB-1:0]                 out_value;
  logic [skf_pkg::GAIN_BITS-1:0] out_gain;

  // datapath nets
  logic [CB:0]               p_sum;
  logic [CB-1:0]             p_sat;
  logic [CB:0]               denom;
  logic [XW-1:0]             x_ext;
  logic [DPW-1:0]            diff_pad;
  logic [KW-1:0]             mul_a;
  logic [CB-1:0]             mul_b;
  logic [PW-1:0]             prod;
  logic [FRACTION_BITS:0]    quot;
  skf_pkg::div_status_t      div_stat;
  logic                      div_start;
  logic [KW-1:0]             k_div;
  logic [CRW-1:0]            corr;
  logic [AW-1:0]             sum_up;
  logic [EB-1:0]             x_new;
  logic [CB-1:0]             cov_new;
  logic                      slot_free;
  logic                      cfg_hit;

  assign samples.ready = state == S_IDLE;
  assign cfg.ready     = 1'b1;

  assign results.valid          = out_valid;
  assign results.filtered_value = out_value;
  assign results.gain           = out_gain;

  // predicted covariance with saturation, and gain denominator
  assign p_sum = {1'b0, cov} + (CB + 1)'(q_noise);
  assign p_sat = p_sum[CB] ? '1 : p_sum[CB-1:0];
  assign denom = {1'b0, p} + (CB + 1)'(r_noise);

  assign x_ext    = XW'(estimate);
  assign diff_pad = DPW'(diff);

  assign div_start = state == S_START;

  // clamp the quotient to 1.0, zero gain for a zero denominator
  assign k_div = den_zero ? '0 : ((quot > ONE_K) ? ONE_K : quot);

  // shared multiplier operand select
  always_comb begin
    mul_a = ONE_K - k;
    mul_b = p;
    case (state)
      S_MUL_LO: begin
        mul_a = k;
        mul_b = diff_pad[CB-1:0];
      end
      S_MUL_HI: begin
        mul_a = k;
        mul_b = diff_pad[DPW-1:CB];
      end
      default: begin
      end
    endcase
  end

  // estimate and covariance update
  assign corr    = acc[AW-1:FRACTION_BITS];
  assign sum_up  = AW'(estimate) + AW'(corr);
  assign x_new   = up ? ((sum_up > AW'(skf_pkg::EST_MAX)) ? skf_pkg::EST_MAX : sum_up[EB-1:0])
                      : (estimate - corr[EB-1:0]);
  assign cov_new = prod[FRACTION_BITS +: CB];

  assign slot_free = !out_valid || results.ready;

  // known register index
  assign cfg_hit = cfg.valid && (cfg.index == skf_pkg::REG_PROCESS_NOISE ||
                                 cfg.index == skf_pkg::REG_MEASUREMENT_NOISE ||
                                 cfg.index == skf_pkg::REG_INITIAL_ESTIMATE);

  skf_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p),
    .den   (denom),
    .quot  (quot),
    .stat  (div_stat)
  );

  skf_mult #(
    .A_BITS (KW),
    .B_BITS (CB)
  ) u_mult (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      q_noise   <= skf_pkg::PROCESS_NOISE_RESET;
      r_noise   <= skf_pkg::MEASUREMENT_NOISE_RESET;
      init_est  <= skf_pkg::INITIAL_ESTIMATE_RESET;
      estimate  <= EB'(skf_pkg::INITIAL_ESTIMATE_RESET);
      cov       <= COV_ONE;
    end else begin
      if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            z     <= XW'(samples.sample) << FRACTION_BITS;
            p     <= p_sat;
            state <= S_START;
          end
        end
        S_START: begin
          den_zero <= denom == '0;
          up       <= z >= x_ext;
          diff     <= (z >= x_ext) ? (z - x_ext) : (x_ext - z);
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            k     <= k_div;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= AW'(prod);
          state <= S_MUL_COV;
        end
        S_MUL_COV: begin
          acc   <= acc + {prod, CB'(0)};
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (slot_free) begin
            estimate  <= x_new;
            cov       <= cov_new;
            out_value <= x_new;
            out_gain  <= skf_pkg::GAIN_BITS'(k);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // register write and filter reload
      if (cfg_hit) begin
        case (cfg.index)
          skf_pkg::REG_PROCESS_NOISE: begin
            q_noise  <= cfg.data;
            estimate <= EB'(init_est);
          end
          skf_pkg::REG_MEASUREMENT_NOISE: begin
            r_noise  <= cfg.data;
            estimate <= EB'(init_est);
          end
          default: begin
            init_est <= cfg.data;
            estimate <= EB'(cfg.data);
          end
        endcase
        cov <= COV_ONE;
      end
    end
  end

  // divider completes only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider done outside of divide state");

  // divider is free when a new division starts
  a_div_free_at_start: assert property (@(posedge clk) disable iff (rst)
    state == S_START |-> !div_stat.busy)
    else $error("divider busy at start");

  // a new result comes only from the update step
  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_UPDATE))
    else $error("result without update");

  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> k <= ONE_K)
    else $error("gain above one");

endmodule

// File: sim/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker
// Watches the sample, result and config channels of the scalar Kalman filter,
// keeps its own copy of the filter registers and state, predicts the estimate
// and gain for every accepted sample and compares them with the results.
// ----------------------------------------------------------------------------
module skf_checker (
  input  logic  clk,
  input  logic  rst,
  skf_sample_if samples,
  skf_result_if results,
  skf_cfg_if    cfg,
  output int    failures,
  output int    pending,
  output int    checked,
  output int    reloads,
  output int    unity_gains,
  output int    zero_gains
);
  import skf_pkg::*;

  localparam logic [63:0] ONE_FIX = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] COV_SAT = (64'd1 << COV_BITS) - 64'd1;

  typedef struct packed {
    logic [EST_BITS-1:0]  filtered_value;
    logic [GAIN_BITS-1:0] gain;
  } filter_out_t;

  // predictor copy of registers and filter state
  logic [REG_BITS-1:0] q_noise;
  logic [REG_BITS-1:0] r_noise;
  logic [REG_BITS-1:0] x_init;
  logic [EST_BITS-1:0] est;
  logic [COV_BITS-1:0] cov;

  filter_out_t expected_q[$];
  int n_fail;
  int n_checked;
  int n_reload;
  int n_unity;
  int n_zero;

  // one filter update: predict covariance, form gain, correct the estimate
  function automatic filter_out_t predict_step(logic [SAMPLE_BITS-1:0] smp);
    logic [63:0] meas;
    logic [63:0] p_pred;
    logic [63:0] denom;
    logic [63:0] k;
    logic [63:0] x;
    logic [63:0] corr;
    filter_out_t res;
    meas   = 64'(smp) << FRACTION_BITS;
    p_pred = 64'(cov) + 64'(q_noise);
    if (p_pred > COV_SAT) p_pred = COV_SAT;
    denom = p_pred + 64'(r_noise);
    k = 64'd0;
    if (denom != 64'd0) k = (p_pred << FRACTION_BITS) / denom;
    if (k > ONE_FIX) k = ONE_FIX;
    // correction is truncated on its magnitude, so no overshoot past the sample
    x = 64'(est);
    if (meas >= x) begin
      corr = (k * (meas - x)) >> FRACTION_BITS;
      x = x + corr;
      if (x > 64'(EST_MAX)) x = 64'(EST_MAX);
    end else begin
      corr = (k * (x - meas)) >> FRACTION_BITS;
      x = x - corr;
    end
    p_pred = ((ONE_FIX - k) * p_pred) >> FRACTION_BITS;
    if (p_pred > COV_SAT) p_pred = COV_SAT;
    est = x[EST_BITS-1:0];
    cov = p_pred[COV_BITS-1:0];
    res.filtered_value = x[EST_BITS-1:0];
    res.gain           = k[GAIN_BITS-1:0];
    return res;
  endfunction

  // transaction monitor and compare
  always @(posedge clk) begin : monitor
    filter_out_t want;
    logic known;
    if (rst) begin
      q_noise = PROCESS_NOISE_RESET;
      r_noise = MEASUREMENT_NOISE_RESET;
      x_init  = INITIAL_ESTIMATE_RESET;
      est     = x_init;
      cov     = COV_BITS'(ONE_FIX);
      expected_q.delete();
      n_fail    = 0;
      n_checked = 0;
      n_reload  = 0;
      n_unity   = 0;
      n_zero    = 0;
    end else begin
      // register write: known index reloads the filter
      if (cfg.valid && cfg.ready) begin
        known = 1'b1;
        case (cfg.index)
          REG_PROCESS_NOISE:     q_noise = cfg.data;
          REG_MEASUREMENT_NOISE: r_noise = cfg.data;
          REG_INITIAL_ESTIMATE:  x_init  = cfg.data;
          default:               known   = 1'b0;
        endcase
        if (known) begin
          est = x_init;
          cov = COV_BITS'(ONE_FIX);
          n_reload++;
        end
      end

      // accepted sample
      if (samples.valid && samples.ready) begin
        want = predict_step(samples.sample);
        if (64'(want.gain) == ONE_FIX) n_unity++;
        if (want.gain == '0) n_zero++;
        expected_q.push_back(want);
      end

      // accepted result
      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, filtered_value %0d gain %0d", $time,
                   results.filtered_value, results.gain);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (results.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value mismatch, expected %0d, actual %0d", $time,
                     want.filtered_value, results.filtered_value);
            n_fail++;
          end
          if (results.gain !== want.gain) begin
            $display("%0t: gain mismatch, expected %0d, actual %0d", $time,
                     want.gain, results.gain);
            n_fail++;
          end
        end
      end
    end
    failures    <= n_fail;
    pending     <= expected_q.size();
    checked     <= n_checked;
    reloads     <= n_reload;
    unity_gains <= n_unity;
    zero_gains  <= n_zero;
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the scalar Kalman filter: a directed pass over the corner
// cases, then random register settings with sensor-like sample streams under
// random stalls on both channels and a long output hold.
// ----------------------------------------------------------------------------
module tb;
  import skf_pkg::*;

  localparam int TOTAL_SAMPLES = 1350;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 40;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [REG_BITS-1:0]       REG_MAX    = '1;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

  logic clk;
  logic rst;

  skf_sample_if samples_ch ();
  skf_result_if results_ch ();
  skf_cfg_if    cfg_ch ();

  int failures;
  int pending;
  int checked;
  int reloads;
  int unity_gains;
  int zero_gains;
  int sent;
  int hold_asks;
  int idle_cycles;
  int sensor_level;

  scalar_kalman_filter uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  skf_checker model_chk (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples_ch),
    .results     (results_ch),
    .cfg         (cfg_ch),
    .failures    (failures),
    .pending     (pending),
    .checked     (checked),
    .reloads     (reloads),
    .unity_gains (unity_gains),
    .zero_gains  (zero_gains)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // sensor-like sample: drifting level with noise, steps and extremes
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      sensor_level = sensor_level + $urandom_range(0, 6) - 3;
      if (sensor_level < 0) sensor_level = 0;
      if (sensor_level > SAMPLE_MAX) sensor_level = SAMPLE_MAX;
      v = sensor_level + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    end else if (r < 80) begin
      v = $urandom_range(0, SAMPLE_MAX);
    end else if (r < 90) begin
      v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
    end else begin
      sensor_level = $urandom_range(0, SAMPLE_MAX);
      v = sensor_level;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // register value: extremes, small and full-range values
  function automatic logic [REG_BITS-1:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return REG_MAX;
      2, 3:    return REG_BITS'($urandom_range(0, 1 << 20));
      4:       return REG_BITS'($urandom);
      default: return REG_BITS'($urandom_range(1 << 16, 10 << 16));
    endcase
  endfunction

  // one sample transaction; valid stays up for a following item
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= value;
    do @(posedge clk); while (!samples_ch.ready);
    sent++;
  endtask

  task automatic pause_samples(input int cycles);
    if (cycles > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // one register write transaction
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [REG_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering samples and wait until every result is back
  task automatic drain();
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // result receiver: random ready runs and stalls, plus long holds on request
  initial begin : receiver
    int stall_left;
    int run_left;
    int hold_done;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        results_ch.ready <= 1'b0;
      end else begin
        if (hold_done != hold_asks) begin
          hold_done  = hold_asks;
          stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && run_left == 0) begin
          run_left   = $urandom_range(1, 60);
          stall_left = idle_gap();
        end
        if (stall_left > 0) begin
          results_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          results_ch.ready <= 1'b1;
          run_left--;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((samples_ch.valid && samples_ch.ready) ||
                 (results_ch.valid && results_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("scalar_kalman_filter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    int phase;
    int phase_len;
    bit burst;
    sent         = 0;
    sensor_level = 128;
    hold_asks    <= 0;
    rst               <= 1'b1;
    samples_ch.valid  <= 1'b0;
    samples_ch.sample <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_PROCESS_NOISE;
    cfg_ch.data       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, sample extremes and alternating bits
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd128);
    send_sample(8'h55);
    send_sample(8'hAA);

    // no noise at all: gain of 1.0, then a zero denominator
    drain();
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_MEASUREMENT_NOISE, '0);
    send_sample(8'd200);
    send_sample(8'd200);
    send_sample(8'd57);

    // largest starting estimate, estimate pulled down from the top
    drain();
    write_reg(REG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RESET);
    write_reg(REG_INITIAL_ESTIMATE, REG_MAX);
    send_sample(8'd255);
    send_sample(8'd0);

    // largest noise on both sides
    drain();
    write_reg(REG_PROCESS_NOISE, REG_MAX);
    write_reg(REG_MEASUREMENT_NOISE, REG_MAX);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd255);

    // write to the unused index leaves the filter running
    drain();
    write_reg(REG_UNUSED, REG_BITS'($urandom));
    send_sample(8'd128);
    send_sample(8'd3);

    // no measurement noise: gain pinned at 1.0
    drain();
    write_reg(REG_PROCESS_NOISE, PROCESS_NOISE_RESET);
    write_reg(REG_MEASUREMENT_NOISE, '0);
    write_reg(REG_INITIAL_ESTIMATE, '0);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd1);

    // back to reset settings
    drain();
    write_reg(REG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RESET);
    write_reg(REG_INITIAL_ESTIMATE, INITIAL_ESTIMATE_RESET);
    send_sample(8'd100);
    send_sample(8'd101);

    // random settings, each followed by a stream of samples
    phase = 0;
    while (sent < TOTAL_SAMPLES) begin
      drain();
      if ($urandom_range(0, 1)) write_reg(REG_PROCESS_NOISE, pick_reg_value());
      if ($urandom_range(0, 1)) write_reg(REG_MEASUREMENT_NOISE, pick_reg_value());
      if ($urandom_range(0, 1)) write_reg(REG_INITIAL_ESTIMATE, pick_reg_value());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, REG_BITS'($urandom));
      phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 150)
                                              : $urandom_range(10, 60);
      burst = ($urandom_range(0, 3) == 0);
      // long output hold while samples keep coming back to back
      if (phase == 2 || phase == 9) begin
        hold_asks <= hold_asks + 1;
        burst = 1'b1;
      end
      sensor_level = $urandom_range(0, SAMPLE_MAX);
      repeat (phase_len) begin
        send_sample(pick_sample());
        if (!burst) pause_samples(idle_gap());
      end
      phase++;
    end

    // wind down and report
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d samples, %0d results checked, %0d filter reloads",
             sent, checked, reloads);
    $display("run: %0d steps at unity gain, %0d at zero gain, %0d long output holds",
             unity_gains, zero_gains, hold_asks);
    if (failures == 0) begin
      $display("scalar_kalman_filter regression: pass");
    end else begin
      $display("scalar_kalman_filter regression: fail");
    end
    $finish;
  end

endmodule
